@@ rtl/smeu_pkg.sv @@
package smeu_pkg;

    typedef enum logic [4:0] {
        OP_PUSH  = 5'd0,
        OP_PUSHR = 5'd1,
        OP_POPR  = 5'd2,
        OP_POP   = 5'd3,
        OP_ADD   = 5'd4,
        OP_SUB   = 5'd5,
        OP_MUL   = 5'd6,
        OP_DIV   = 5'd7,
        OP_JMP   = 5'd8,
        OP_JEQ   = 5'd9,
        OP_JNE   = 5'd10,
        OP_JA    = 5'd11,
        OP_JAE   = 5'd12,
        OP_JB    = 5'd13,
        OP_JBE   = 5'd14,
        OP_CALL  = 5'd15,
        OP_RET   = 5'd16,
        OP_IN    = 5'd17,
        OP_OUT   = 5'd18
    } opcode_t;

    typedef enum logic [1:0] {
        FLT_NONE  = 2'd0,
        FLT_STACK = 2'd1,
        FLT_DIV0  = 2'd2,
        FLT_FRAME = 2'd3
    } fault_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/stack_machine_execute_unit.sv @@
// Stack-machine execute unit.
// Command channel: drive kind, operand, jump_target and in_value with start
// high; the beat is taken at a rising edge where busy is low. busy rises the
// next cycle and stays high until the cycle in which the result is shown.
// Result channel: next_pc, out_valid, out_value and fault appear for exactly
// one cycle with done high. The receiver cannot stall, so it must sample then.
// Sequence: the memories are read in ST_READ, after the command is taken
// (synchronous read of the data stack, register file and frame stack),
// ST_EXEC executes and writes back, and the result shows in ST_DONE; a new
// command is taken in the done cycle. div waits in ST_DIV between ST_EXEC
// and ST_DONE while the restoring divider works out one quotient bit per cycle.
// The top two stack words are read from two read ports of the stack memory;
// one instruction is in flight at a time, so no forwarding is needed.
// Reset clears pc, stack depth and frame depth; the register file carries a
// valid bit per entry so unwritten registers read as zero. The stack and
// frame memories hold no reset values: only entries below the counts are used.
// A faulting instruction leaves all state unchanged and reports next_pc = pc.
module stack_machine_execute_unit
    import smeu_pkg::*;
#(
    parameter int STACK_DEPTH = 256,
    parameter int NUM_REGS    = 256,
    parameter int CALL_DEPTH  = 64,
    parameter int PC_WIDTH    = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [4:0]          kind,
    input  logic signed [31:0]  operand,
    input  logic [15:0]         jump_target,
    input  logic signed [31:0]  in_value,
    output logic                done,
    output logic [15:0]         next_pc,
    output logic                out_valid,
    output logic signed [31:0]  out_value,
    output logic [1:0]          fault
);

    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int RAW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int FAW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
    localparam int FCW = $clog2(CALL_DEPTH + 1);

    // memories
    logic [31:0]         stack_mem [STACK_DEPTH];
    logic [31:0]         reg_mem   [NUM_REGS];
    logic [SCW-1:0]      fdepth_mem [CALL_DEPTH];
    logic [PC_WIDTH-1:0] fpc_mem    [CALL_DEPTH];
    logic [NUM_REGS-1:0] reg_vld_reg;

    state_t state_reg, state_next;
    logic [PC_WIDTH-1:0] pc_reg, pc_next;
    logic [SCW-1:0]      sc_reg, sc_next;
    logic [FCW-1:0]      fc_reg, fc_next;

    // command hold
    logic [4:0]  kind_reg;
    logic [31:0] opd_reg;
    logic [15:0] tgt_reg;
    logic [31:0] inv_reg;

    // read data
    logic [31:0]         t_rd, s_rd, r_rd;
    logic                r_vld_rd;
    logic [SCW-1:0]      fd_rd;
    logic [PC_WIDTH-1:0] fp_rd;

    // result
    logic [PC_WIDTH-1:0] npc_reg, npc_next;
    logic                ov_reg, ov_next;
    logic [31:0]         oval_reg, oval_next;
    fault_t              flt_reg, flt_next;

    // write ports
    logic              sw_en;
    logic [SAW-1:0]    sw_addr;
    logic [31:0]       sw_data;
    logic              rw_en;
    logic [RAW-1:0]    rw_addr;
    logic              fw_en;

    div_req_t div_req;
    div_rsp_t div_rsp;

    smeu_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    logic                accept;
    logic [SCW-1:0]      sc_m1, sc_m2;
    logic [FCW-1:0]      fc_m1;
    logic [PC_WIDTH-1:0] pc1, pc2, tgt_pc;
    logic                reg_ok;
    logic [31:0]         reg_val;
    logic [31:0]         alu;
    logic                take;
    logic                ge2, ge1, full;

    assign accept = start && !busy;
    assign sc_m1  = sc_reg - SCW'(1);
    assign sc_m2  = sc_reg - SCW'(2);
    assign fc_m1  = fc_reg - FCW'(1);
    assign pc1    = pc_reg + PC_WIDTH'(1);
    assign pc2    = pc_reg + PC_WIDTH'(2);
    assign tgt_pc = PC_WIDTH'({16'd0, tgt_reg});
    assign reg_ok = ({24'd0, opd_reg[7:0]} < 32'(NUM_REGS));
    assign reg_val = (reg_ok && r_vld_rd) ? r_rd : 32'd0;
    assign ge1    = (sc_reg >= SCW'(1));
    assign ge2    = (sc_reg >= SCW'(2));
    assign full   = (sc_reg >= SCW'(STACK_DEPTH));

    // memory reads: issued in ST_READ, data valid in ST_EXEC
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            t_rd     <= stack_mem[sc_m1[SAW-1:0]];
            s_rd     <= stack_mem[sc_m2[SAW-1:0]];
            r_rd     <= reg_mem[opd_reg[RAW-1:0]];
            r_vld_rd <= reg_vld_reg[opd_reg[RAW-1:0]];
            fd_rd    <= fdepth_mem[fc_m1[FAW-1:0]];
            fp_rd    <= fpc_mem[fc_m1[FAW-1:0]];
        end
        if (sw_en)
            stack_mem[sw_addr] <= sw_data;
        if (rw_en)
            reg_mem[rw_addr] <= t_rd;
        if (fw_en)
        begin
            fdepth_mem[fc_reg[FAW-1:0]] <= sc_reg;
            fpc_mem[fc_reg[FAW-1:0]]    <= pc2;
        end
    end

    always_comb
    begin
        case (opcode_t'(kind_reg))
            OP_ADD:  alu = t_rd + s_rd;
            OP_SUB:  alu = t_rd - s_rd;
            default: alu = t_rd * s_rd;
        endcase
        case (opcode_t'(kind_reg))
            OP_JEQ:  take = (t_rd == s_rd);
            OP_JNE:  take = (t_rd != s_rd);
            OP_JA:   take = ($signed(t_rd) >  $signed(s_rd));
            OP_JAE:  take = ($signed(t_rd) >= $signed(s_rd));
            OP_JB:   take = ($signed(t_rd) <  $signed(s_rd));
            default: take = ($signed(t_rd) <= $signed(s_rd));
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        sc_next    = sc_reg;
        fc_next    = fc_reg;
        npc_next   = npc_reg;
        ov_next    = 1'b0;
        oval_next  = 32'd0;
        flt_next   = flt_reg;
        sw_en      = 1'b0;
        sw_addr    = sc_reg[SAW-1:0];
        sw_data    = opd_reg;
        rw_en      = 1'b0;
        rw_addr    = opd_reg[RAW-1:0];
        fw_en      = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = t_rd;
        div_req.divisor  = s_rd;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                flt_next   = FLT_NONE;
                npc_next   = pc1;
                case (opcode_t'(kind_reg))
                    OP_PUSH, OP_PUSHR, OP_IN:
                    begin
                        if (full)
                            flt_next = FLT_STACK;
                        else
                        begin
                            sw_en   = 1'b1;
                            sw_data = (kind_reg == OP_PUSH) ? opd_reg :
                                      (kind_reg == OP_PUSHR) ? reg_val : inv_reg;
                            sc_next = sc_reg + SCW'(1);
                            if (kind_reg != OP_IN)
                                npc_next = pc2;
                        end
                    end
                    OP_POPR, OP_POP, OP_OUT:
                    begin
                        if (!ge1)
                            flt_next = FLT_STACK;
                        else
                        begin
                            sc_next = sc_m1;
                            if (kind_reg == OP_POPR)
                            begin
                                rw_en    = reg_ok;
                                npc_next = pc2;
                            end
                            if (kind_reg == OP_OUT)
                            begin
                                ov_next   = 1'b1;
                                oval_next = t_rd;
                            end
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL:
                    begin
                        if (!ge2)
                            flt_next = FLT_STACK;
                        else
                        begin
                            sw_en   = 1'b1;
                            sw_addr = sc_m2[SAW-1:0];
                            sw_data = alu;
                            sc_next = sc_m1;
                        end
                    end
                    OP_DIV:
                    begin
                        if (!ge2)
                            flt_next = FLT_STACK;
                        else if (s_rd == 32'd0)
                            flt_next = FLT_DIV0;
                        else
                        begin
                            div_req.start = 1'b1;
                            state_next    = ST_DIV;
                        end
                    end
                    OP_JMP:
                    begin
                        npc_next = tgt_pc;
                    end
                    OP_JEQ, OP_JNE, OP_JA, OP_JAE, OP_JB, OP_JBE:
                    begin
                        if (!ge2)
                            flt_next = FLT_STACK;
                        else
                            npc_next = take ? tgt_pc : pc2;
                    end
                    OP_CALL:
                    begin
                        if (fc_reg >= FCW'(CALL_DEPTH))
                            flt_next = FLT_FRAME;
                        else
                        begin
                            fw_en    = 1'b1;
                            fc_next  = fc_reg + FCW'(1);
                            npc_next = tgt_pc;
                        end
                    end
                    OP_RET:
                    begin
                        if (fc_reg == '0)
                            flt_next = FLT_FRAME;
                        else if (sc_reg < fd_rd)
                            flt_next = FLT_STACK;
                        else
                        begin
                            sc_next  = fd_rd;
                            npc_next = fp_rd;
                            fc_next  = fc_m1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (flt_next != FLT_NONE)
                begin
                    npc_next  = pc_reg;
                    ov_next   = 1'b0;
                    oval_next = 32'd0;
                end
                if (state_next == ST_DONE)
                    pc_next = npc_next;
            end
            ST_DIV:
            begin
                ov_next  = 1'b0;
                if (div_rsp.done)
                begin
                    // write the quotient over the second word and drop the top
                    sw_en      = 1'b1;
                    sw_addr    = sc_m2[SAW-1:0];
                    sw_data    = div_rsp.quotient;
                    sc_next    = sc_m1;
                    npc_next   = pc1;
                    pc_next    = pc1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                ov_next   = ov_reg;
                oval_next = oval_reg;
                state_next = accept ? ST_READ : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pc_reg      <= '0;
            sc_reg      <= '0;
            fc_reg      <= '0;
            reg_vld_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            sc_reg    <= sc_next;
            fc_reg    <= fc_next;
            if (rw_en)
                reg_vld_reg[rw_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            opd_reg  <= operand;
            tgt_reg  <= jump_target;
            inv_reg  <= in_value;
        end
        npc_reg  <= npc_next;
        ov_reg   <= ov_next;
        oval_reg <= oval_next;
        flt_reg  <= flt_next;
    end

    assign busy      = (state_reg == ST_READ) || (state_reg == ST_EXEC) ||
                       (state_reg == ST_DIV);
    assign done      = (state_reg == ST_DONE);
    assign next_pc   = 16'(npc_reg);
    assign out_valid = ov_reg;
    assign out_value = oval_reg;
    assign fault     = flt_reg;

    a_sc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sc_reg <= SCW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");
    a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= FCW'(CALL_DEPTH))
        else $error("frame depth beyond capacity");
    a_fault_pc: assert property (@(posedge clk) disable iff (!rst_n)
        done && (fault != FLT_NONE) |-> $stable(pc_reg))
        else $error("faulting beat moved pc");
    a_fault_out: assert property (@(posedge clk) disable iff (!rst_n)
        done && (fault != FLT_NONE) |-> !out_valid)
        else $error("faulting beat emitted a value");
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider finished outside division");

endmodule

@@ rtl/smeu_divider.sv @@
module smeu_divider
    import smeu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [31:0] shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[30:0], quo_reg[31]};
        trial     = {1'b0, shifted} - {1'b0, dvs_reg};
        if (req.start)
        begin
            // work on magnitudes; restore the sign at the end
            rem_next  = '0;
            quo_next  = req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
            dvs_next  = req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
            neg_next  = req.dividend[31] ^ req.divisor[31];
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

endmodule

@@ sim/smeu_checker.sv @@
`timescale 1ns / 100ps

module smeu_checker
    import smeu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [4:0]         kind,
    input  logic signed [31:0] operand,
    input  logic [15:0]        jump_target,
    input  logic signed [31:0] in_value,
    input  logic               done,
    input  logic [15:0]        next_pc,
    input  logic               out_valid,
    input  logic signed [31:0] out_value,
    input  logic [1:0]         fault,
    output int                 errors,
    output int                 pending
);

    localparam int STACK_DEPTH = 256;
    localparam int NUM_REGS    = 256;
    localparam int CALL_DEPTH  = 64;

    typedef struct packed {
        logic [15:0] pc;
        logic        ov;
        logic [31:0] val;
        fault_t      flt;
    } step_result_t;

    logic [15:0] pc_q;
    logic [31:0] stack_mem [STACK_DEPTH];
    int          depth;
    logic [31:0] regs [NUM_REGS];
    int          frame_depth [CALL_DEPTH];
    logic [15:0] frame_ret [CALL_DEPTH];
    int          frames;

    step_result_t expected_steps [$];

    // Advance the shadow machine by one instruction and return its result.
    function automatic step_result_t execute(logic [4:0] k, logic [31:0] op,
                                             logic [15:0] tgt, logic [31:0] inv);
        step_result_t r;
        logic [15:0]  npc;
        logic [15:0]  npc2;
        logic [31:0]  t;
        logic [31:0]  s;
        logic [31:0]  res;
        logic [7:0]   ri;
        logic         take;
        fault_t       f;
        npc  = pc_q + 16'd1;
        npc2 = pc_q + 16'd2;
        t    = (depth >= 1) ? stack_mem[depth-1] : 32'd0;
        s    = (depth >= 2) ? stack_mem[depth-2] : 32'd0;
        ri   = op[7:0];
        f    = FLT_NONE;
        r.ov = 1'b0;
        r.val = 32'd0;
        case (k)
            OP_PUSH, OP_PUSHR, OP_IN:
                if (depth >= STACK_DEPTH) f = FLT_STACK;
                else
                begin
                    if (k == OP_PUSH) stack_mem[depth] = op;
                    else if (k == OP_PUSHR) stack_mem[depth] = regs[ri];
                    else stack_mem[depth] = inv;
                    depth++;
                    if (k != OP_IN) npc = npc2;
                end
            OP_POPR, OP_POP, OP_OUT:
                if (depth < 1) f = FLT_STACK;
                else
                begin
                    if (k == OP_POPR)
                    begin
                        regs[ri] = t;
                        npc = npc2;
                    end
                    else if (k == OP_OUT)
                    begin
                        r.ov = 1'b1;
                        r.val = t;
                    end
                    depth--;
                end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                if (depth < 2) f = FLT_STACK;
                else if (k == OP_DIV && s == 32'd0) f = FLT_DIV0;
                else
                begin
                    if (k == OP_ADD) res = t + s;
                    else if (k == OP_SUB) res = t - s;
                    else if (k == OP_MUL) res = t * s;
                    else res = 32'(longint'($signed(t)) / longint'($signed(s)));
                    stack_mem[depth-2] = res;
                    depth--;
                end
            OP_JMP: npc = tgt;
            OP_JEQ, OP_JNE, OP_JA, OP_JAE, OP_JB, OP_JBE:
                if (depth < 2) f = FLT_STACK;
                else
                begin
                    case (k)
                        OP_JEQ:  take = (t == s);
                        OP_JNE:  take = (t != s);
                        OP_JA:   take = ($signed(t) >  $signed(s));
                        OP_JAE:  take = ($signed(t) >= $signed(s));
                        OP_JB:   take = ($signed(t) <  $signed(s));
                        default: take = ($signed(t) <= $signed(s));
                    endcase
                    npc = take ? tgt : npc2;
                end
            OP_CALL:
                if (frames >= CALL_DEPTH) f = FLT_FRAME;
                else
                begin
                    frame_depth[frames] = depth;
                    frame_ret[frames] = npc2;
                    frames++;
                    npc = tgt;
                end
            OP_RET:
                if (frames < 1) f = FLT_FRAME;
                else if (depth < frame_depth[frames-1]) f = FLT_STACK;
                else
                begin
                    depth = frame_depth[frames-1];
                    npc = frame_ret[frames-1];
                    frames--;
                end
            default: ;
        endcase
        if (f != FLT_NONE)
        begin
            npc = pc_q;
            r.ov = 1'b0;
            r.val = 32'd0;
        end
        pc_q = npc;
        r.pc = npc;
        r.flt = f;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        step_result_t e;
        if (!rst_n)
        begin
            pc_q = '0;
            depth = 0;
            frames = 0;
            errors = 0;
            foreach (regs[i]) regs[i] = '0;
            expected_steps.delete();
            pending = 0;
        end
        else
        begin
            // Compare before predicting: a beat accepted at the done edge yields later.
            if (done)
            begin
                if (expected_steps.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with nothing expected, pc %h", $time, next_pc);
                end
                else
                begin
                    e = expected_steps.pop_front();
                    if (next_pc !== e.pc)
                    begin
                        errors++;
                        $display("%0t: next_pc expected %h actual %h", $time, e.pc, next_pc);
                    end
                    if (out_valid !== e.ov)
                    begin
                        errors++;
                        $display("%0t: out_valid expected %b actual %b", $time, e.ov, out_valid);
                    end
                    if (out_value !== e.val)
                    begin
                        errors++;
                        $display("%0t: out_value expected %h actual %h", $time, e.val,
                                 out_value);
                    end
                    if (fault !== e.flt)
                    begin
                        errors++;
                        $display("%0t: fault expected %0d actual %0d", $time, e.flt, fault);
                    end
                end
            end
            if (start && !busy)
                expected_steps = {expected_steps,
                                  execute(kind, operand, jump_target, in_value)};
            pending = expected_steps.size();
        end
    end

endmodule

@@ sim/tb_stack_machine_execute_unit.sv @@
`timescale 1ns / 100ps

module tb_stack_machine_execute_unit;
    import smeu_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [4:0]         kind = '0;
    logic signed [31:0] operand = '0;
    logic [15:0]        jump_target = '0;
    logic signed [31:0] in_value = '0;
    logic               done;
    logic [15:0]        next_pc;
    logic               out_valid;
    logic signed [31:0] out_value;
    logic [1:0]         fault;
    int                 errors;
    int                 pending;
    int                 idle_pct = 0;

    always #4 clk = ~clk;

    stack_machine_execute_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .operand(operand), .jump_target(jump_target), .in_value(in_value),
        .done(done), .next_pc(next_pc), .out_valid(out_valid), .out_value(out_value),
        .fault(fault)
    );

    smeu_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .operand(operand), .jump_target(jump_target), .in_value(in_value),
        .done(done), .next_pc(next_pc), .out_valid(out_valid), .out_value(out_value),
        .fault(fault), .errors(errors), .pending(pending)
    );

    // Issue one instruction beat: optional idle cycles first, then hold start
    // until the block takes it. Always returns right after an accepting edge.
    task automatic issue(logic [4:0] k, logic [31:0] op, logic [15:0] tgt, logic [31:0] inv);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        kind        <= k;
        operand     <= op;
        jump_target <= tgt;
        in_value    <= inv;
        start       <= 1'b1;
        do @(posedge clk); while (busy);
    endtask

    task automatic issue_op(logic [4:0] k, logic [31:0] op);
        issue(k, op, 16'($urandom), $urandom);
    endtask

    // Pick an opcode with a mild bias towards pushes so the stack grows
    // deep enough to reach the interesting boundaries now and then.
    function automatic logic [4:0] pick_kind();
        int p;
        p = $urandom_range(99);
        if (p < 12) return OP_PUSH;
        if (p < 20) return OP_PUSHR;
        if (p < 28) return OP_IN;
        if (p < 35) return OP_POPR;
        if (p < 41) return OP_POP;
        if (p < 47) return OP_OUT;
        if (p < 63) return 5'($urandom_range(OP_ADD, OP_DIV));
        if (p < 79) return 5'($urandom_range(OP_JMP, OP_JBE));
        if (p < 86) return OP_CALL;
        if (p < 94) return OP_RET;
        return 5'($urandom_range(19, 31));
    endfunction

    // Operands: plenty of small values so compares tie and divisors hit zero,
    // with full-width randoms and the extremes mixed in.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'($urandom_range(3));
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int n);
        int i;
        int j;
        i = 0;
        while (i < n)
        begin
            if ($urandom_range(249) == 0)
            begin
                // Fill the data stack to overflow, then drain it past empty.
                for (j = 0; j < 262; j++) issue_op(OP_PUSH, pick_value());
                for (j = 0; j < 262; j++) issue_op(OP_POP, '0);
                i += 524;
            end
            else if ($urandom_range(249) == 0)
            begin
                // Nest calls past the frame limit, then unwind past empty.
                for (j = 0; j < 67; j++) issue_op(OP_CALL, '0);
                for (j = 0; j < 67; j++) issue_op(OP_RET, '0);
                i += 134;
            end
            else
            begin
                issue(pick_kind(), pick_value(), 16'($urandom), pick_value());
                i++;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: underflow on an empty machine, the extremes, a subset of the opcodes and an undefined one.
        issue_op(OP_POP, '0);
        issue_op(OP_OUT, '0);
        issue_op(OP_ADD, '0);
        issue_op(OP_JEQ, '0);
        issue_op(OP_RET, '0);
        issue_op(OP_PUSH, 32'h7fff_ffff);
        issue_op(OP_PUSH, 32'h8000_0000);
        issue_op(OP_ADD, '0);
        issue_op(OP_PUSH, 32'hffff_ffff);
        issue_op(OP_PUSH, 32'h8000_0000);
        issue_op(OP_DIV, '0);
        issue_op(OP_PUSH, '0);
        issue_op(OP_PUSH, 32'd5);
        issue_op(OP_DIV, '0);
        issue_op(OP_POPR, 32'hffff_ffff);
        issue_op(OP_PUSHR, 32'h0000_00ff);
        issue_op(OP_PUSHR, '0);
        issue(OP_CALL, '0, 16'hffff, '0);
        issue_op(OP_POP, '0);
        issue_op(OP_POP, '0);
        issue_op(OP_RET, '0);
        issue(OP_JA, '0, 16'hffff, '0);
        issue_op(OP_PUSH, '0);
        issue(OP_IN, '0, '0, 32'h8000_0000);
        issue_op(OP_OUT, '0);
        issue_op(5'd31, 32'hffff_ffff);

        idle_pct = 17;
        random_phase(650);
        idle_pct = 88;
        random_phase(650);
        idle_pct = 0;
        random_phase(650);

        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
